>>> hdl/assert_macros.svh
// Assertion macros shared by the frame formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRF_ASSERT(lbl, prop, msg)
`define SRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/srf_pkg.sv
// Types, constants and helpers of the sensor report frame formatter.
`default_nettype none
package srf_pkg;
  localparam int TEMP_W      = 15;
  localparam int HUM_W       = 14;
  localparam int LIGHT_W     = 16;
  localparam int NODE_W      = 8;
  localparam int MAG_W       = 14;
  localparam int VAL_W       = 16;
  localparam int DIGITS      = 13;
  localparam int IDX_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_SYNC   = 1'b1;

  localparam logic [IDX_W-1:0] LAST_SYNC   = 5'd3;
  localparam logic [IDX_W-1:0] LAST_REPORT = 5'd20;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_END   = 8'h40;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef struct packed {
    logic               cmd;
    logic               climate_error;
    logic               light_error;
    logic               neg;
    logic [MAG_W-1:0]   temp_mag;
    logic [HUM_W-1:0]   hum;
    logic [LIGHT_W-1:0] light;
  } entry_t;

  typedef struct packed {
    logic                   cmd;
    logic                   climate_error;
    logic                   light_error;
    logic                   neg;
    logic [DIGITS-1:0][3:0] dig;
  } frame_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction
endpackage
`default_nettype wire

>>> hdl/srf_if.sv
// Input item and output byte channel interfaces.
`default_nettype none
interface srf_item_if;
  import srf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [TEMP_W-1:0]  temp_sample_0;
  logic signed [TEMP_W-1:0]  temp_sample_1;
  logic signed [TEMP_W-1:0]  temp_sample_2;
  logic        [HUM_W-1:0]   hum_sample_0;
  logic        [HUM_W-1:0]   hum_sample_1;
  logic        [HUM_W-1:0]   hum_sample_2;
  logic        [LIGHT_W-1:0] light_sample_0;
  logic        [LIGHT_W-1:0] light_sample_1;
  logic        [LIGHT_W-1:0] light_sample_2;
  logic                      climate_error;
  logic                      light_error;

  modport source (output valid, cmd, temp_sample_0, temp_sample_1, temp_sample_2,
                  hum_sample_0, hum_sample_1, hum_sample_2, light_sample_0,
                  light_sample_1, light_sample_2, climate_error, light_error,
                  input ready);
  modport sink (input valid, cmd, temp_sample_0, temp_sample_1, temp_sample_2,
                hum_sample_0, hum_sample_1, hum_sample_2, light_sample_0,
                light_sample_1, light_sample_2, climate_error, light_error,
                output ready);
endinterface

interface srf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface
`default_nettype wire

>>> hdl/sensor_report_frame_formatter.sv
// Sensor report frame formatter: top level with APB register and channel wiring.
// Each accepted item produces one ASCII frame on the byte channel, one byte per
// cycle while the sink is ready: 4 bytes for a sync request, 21 for a report.
// Items enter a two-entry queue; the back end converts a report to decimal with
// one shared divide-by-ten unit while the previous frame is still being sent,
// so with a ready sink frames are paced by the one-byte output channel, except
// that a report after a short sync frame can leave a gap while it converts.
// node_address sits at byte address 0 and resets to 1.
`default_nettype none
module sensor_report_frame_formatter #(
  parameter int QUEUE_DEPTH = srf_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [srf_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [srf_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [srf_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  srf_item_if.sink                            item,
  srf_frame_if.source                         frame
);
  import srf_pkg::*;

  localparam logic REG_NODE_ADDRESS = 1'b0;

  logic [NODE_W-1:0] node_address;
  logic              cfg_write;
  logic              push;
  entry_t            push_entry;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  entry_t            q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODE_ADDRESS);
  assign prdata    = (paddr[2] == REG_NODE_ADDRESS) ?
                     {{(APB_DATA_W - NODE_W){1'b0}}, node_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 8'd1;
    end else if (cfg_write) begin
      node_address <= pwdata[NODE_W-1:0];
    end
  end

  srf_front u_front (
    .item       (item),
    .full       (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  srf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  srf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .node_address (node_address),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .frame        (frame)
  );
endmodule
`default_nettype wire

>>> hdl/srf_front.sv
// Front end: accepts items, takes medians and prepares the queue entry.
`default_nettype none
module srf_front (
  srf_item_if.sink        item,
  input  wire logic       full,
  output logic            push,
  output srf_pkg::entry_t push_entry
);
  import srf_pkg::*;

  function automatic logic signed [TEMP_W-1:0] med3s(
    input logic signed [TEMP_W-1:0] a,
    input logic signed [TEMP_W-1:0] b,
    input logic signed [TEMP_W-1:0] c
  );
    logic signed [TEMP_W-1:0] lo;
    logic signed [TEMP_W-1:0] hi;
    logic signed [TEMP_W-1:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  function automatic logic [LIGHT_W-1:0] med3u(
    input logic [LIGHT_W-1:0] a,
    input logic [LIGHT_W-1:0] b,
    input logic [LIGHT_W-1:0] c
  );
    logic [LIGHT_W-1:0] lo;
    logic [LIGHT_W-1:0] hi;
    logic [LIGHT_W-1:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  logic signed [TEMP_W-1:0] temp_med;
  logic        [TEMP_W:0]   temp_ext;
  logic        [TEMP_W:0]   temp_abs;
  logic        [TEMP_W:0]   temp_wrap;
  logic        [LIGHT_W-1:0] hum_med;

  assign item.ready = !full;
  assign push       = item.valid && !full;

  always_comb begin
    temp_med  = med3s(item.temp_sample_0, item.temp_sample_1, item.temp_sample_2);
    temp_ext  = {temp_med[TEMP_W-1], temp_med};
    temp_abs  = temp_med[TEMP_W-1] ? (~temp_ext + 16'd1) : temp_ext;
    temp_wrap = (temp_abs >= 16'd10000) ? (temp_abs - 16'd10000) : temp_abs;
    hum_med   = med3u({2'b00, item.hum_sample_0}, {2'b00, item.hum_sample_1},
                      {2'b00, item.hum_sample_2});

    push_entry.cmd           = item.cmd;
    push_entry.climate_error = item.climate_error;
    push_entry.light_error   = item.light_error;
    push_entry.neg           = temp_med[TEMP_W-1];
    push_entry.temp_mag      = temp_wrap[MAG_W-1:0];
    push_entry.hum           = hum_med[HUM_W-1:0];
    push_entry.light         = med3u(item.light_sample_0, item.light_sample_1,
                                     item.light_sample_2);
  end
endmodule
`default_nettype wire

>>> hdl/srf_queue.sv
// Short entry queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"
module srf_queue #(
  parameter int DEPTH = srf_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire srf_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output srf_pkg::entry_t      head
);
  import srf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr_next;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  `SRF_ASSERT(a_count_bound, (count <= CNT_W'(DEPTH)), "queue count above depth")
  `SRF_ASSERT(a_no_overflow, (full |-> !push), "push into full queue")
  `SRF_ASSERT(a_no_underflow, (pop |-> !empty), "pop from empty queue")
endmodule
`default_nettype wire

>>> hdl/srf_back.sv
// Back end: decimal conversion through a shared divide-by-ten unit and byte emission.
`default_nettype none
`include "assert_macros.svh"
module srf_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [srf_pkg::NODE_W-1:0] node_address,
  input  wire logic                       q_empty,
  input  wire srf_pkg::entry_t            q_head,
  output logic                            pop,
  srf_frame_if.source                     frame
);
  import srf_pkg::*;

  localparam logic [3:0] STEP_LIGHT = 4'd0;
  localparam logic [3:0] STEP_TEMP  = 4'd5;
  localparam logic [3:0] STEP_HUM   = 4'd9;
  localparam logic [3:0] STEP_CLAMP = 4'd10;
  localparam logic [3:0] STEP_LAST  = 4'd12;
  localparam logic [12:0] HUM_MAX   = 13'd99;

  // converter
  logic                   hold;
  logic                   complete;
  logic [3:0]             step;
  entry_t                 cur;
  logic [VAL_W-1:0]       val;
  logic [DIGITS-1:0][3:0] dig;
  logic [VAL_W-1:0]       x;
  logic [2*VAL_W-1:0]     prod;
  logic [12:0]            quo;
  logic [VAL_W-1:0]       rem;
  logic                   working;

  // emitter
  logic                   fvalid;
  logic [IDX_W-1:0]       fk;
  frame_t                 frame_r;
  logic [IDX_W-1:0]       last_idx;
  logic                   at_last;
  logic                   out_fire;
  logic                   emit_free;
  logic                   handoff;

  assign working   = hold && !complete;
  assign last_idx  = (frame_r.cmd == CMD_SYNC) ? LAST_SYNC : LAST_REPORT;
  assign at_last   = (fk == last_idx);
  assign out_fire  = fvalid && frame.ready;
  assign emit_free = !fvalid || (out_fire && at_last);
  assign handoff   = hold && complete && emit_free;
  assign pop       = !q_empty && (!hold || handoff);

  always_comb begin
    case (step)
      STEP_LIGHT: x = cur.light;
      STEP_TEMP:  x = {2'b00, cur.temp_mag};
      STEP_HUM:   x = {2'b00, cur.hum};
      default:    x = val;
    endcase
    prod = x * 16'hCCCD;
    quo  = prod[31:19];
    rem  = x - ({3'b000, quo} << 3) - ({3'b000, quo} << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold     <= 1'b0;
      complete <= 1'b0;
      step     <= '0;
      fvalid   <= 1'b0;
      fk       <= '0;
    end else begin
      if (pop) begin
        hold     <= 1'b1;
        complete <= (q_head.cmd == CMD_SYNC);
        step     <= '0;
      end else if (handoff) begin
        hold <= 1'b0;
      end else if (working) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          complete <= 1'b1;
        end
      end
      if (handoff) begin
        fvalid <= 1'b1;
        fk     <= '0;
      end else if (out_fire) begin
        if (at_last) begin
          fvalid <= 1'b0;
        end else begin
          fk <= fk + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (working) begin
      dig[step] <= rem[3:0];
      if (step == STEP_CLAMP) begin
        val <= (quo > HUM_MAX) ? {3'b000, HUM_MAX} : {3'b000, quo};
      end else begin
        val <= {3'b000, quo};
      end
    end
    if (handoff) begin
      frame_r.cmd           <= cur.cmd;
      frame_r.climate_error <= cur.climate_error;
      frame_r.light_error   <= cur.light_error;
      frame_r.neg           <= cur.neg;
      frame_r.dig           <= dig;
    end
  end

  // node identifier
  logic [NODE_W-1:0] addr_eff;
  logic [NODE_W-1:0] addr_m1;
  logic [15:0]       letter_prod;
  logic [15:0]       addr_prod;
  logic [4:0]        addr_quo;
  logic [NODE_W-1:0] addr_rem;
  logic [7:0]        id_letter;
  logic [7:0]        id_tens;
  logic [7:0]        id_ones;

  always_comb begin
    addr_eff    = (node_address == '0) ? 8'd1 : node_address;
    addr_m1     = addr_eff - 8'd1;
    letter_prod = {8'd0, addr_m1} * 16'd205;
    addr_prod   = {8'd0, addr_eff} * 16'd205;
    addr_quo    = addr_prod[15:11];
    addr_rem    = addr_eff - ({3'b000, addr_quo} << 3) - ({3'b000, addr_quo} << 1);
    id_letter   = CH_A + {3'b000, letter_prod[15:11]};
    id_tens     = (addr_rem == '0) ? CH_ONE : CH_ZERO;
    id_ones     = (addr_rem == '0) ? CH_ZERO : digit_char(addr_rem[3:0]);
  end

  logic t_blank;
  logic h_blank;
  logic l4_blank;
  logic l3_blank;
  logic l2_blank;
  logic l1_blank;
  logic ce;
  logic le;
  logic [7:0] byte_out;

  always_comb begin
    ce       = frame_r.climate_error;
    le       = frame_r.light_error;
    t_blank  = (frame_r.dig[8] == 4'd0);
    h_blank  = (frame_r.dig[12] == 4'd0);
    l4_blank = (frame_r.dig[4] == 4'd0);
    l3_blank = l4_blank && (frame_r.dig[3] == 4'd0);
    l2_blank = l3_blank && (frame_r.dig[2] == 4'd0);
    l1_blank = l2_blank && (frame_r.dig[1] == 4'd0);
    case (fk)
      5'd0:  byte_out = (frame_r.cmd == CMD_SYNC) ? CH_T : CH_D;
      5'd1:  byte_out = id_letter;
      5'd2:  byte_out = id_tens;
      5'd3:  byte_out = id_ones;
      5'd4:  byte_out = CH_T;
      5'd5:  byte_out = (ce || frame_r.neg) ? CH_MINUS : CH_SPACE;
      5'd6:  byte_out = ce ? CH_NINE :
                        (t_blank ? CH_SPACE : digit_char(frame_r.dig[8]));
      5'd7:  byte_out = ce ? CH_NINE : digit_char(frame_r.dig[7]);
      5'd8:  byte_out = CH_DOT;
      5'd9:  byte_out = ce ? CH_NINE : digit_char(frame_r.dig[6]);
      5'd10: byte_out = ce ? CH_NINE : digit_char(frame_r.dig[5]);
      5'd11: byte_out = CH_H;
      5'd12: byte_out = ce ? CH_MINUS :
                        (h_blank ? CH_SPACE : digit_char(frame_r.dig[12]));
      5'd13: byte_out = ce ? CH_ONE : digit_char(frame_r.dig[11]);
      5'd14: byte_out = CH_I;
      5'd15: byte_out = le ? CH_SIX :
                        (l4_blank ? CH_SPACE : digit_char(frame_r.dig[4]));
      5'd16: byte_out = le ? CH_FIVE :
                        (l3_blank ? CH_SPACE : digit_char(frame_r.dig[3]));
      5'd17: byte_out = le ? CH_FIVE :
                        (l2_blank ? CH_SPACE : digit_char(frame_r.dig[2]));
      5'd18: byte_out = le ? CH_THREE :
                        (l1_blank ? CH_SPACE : digit_char(frame_r.dig[1]));
      5'd19: byte_out = le ? CH_FIVE : digit_char(frame_r.dig[0]);
      default: byte_out = CH_END;
    endcase
  end

  assign frame.valid      = fvalid;
  assign frame.frame_byte = byte_out;
  assign frame.frame_end  = at_last;

  `SRF_ASSERT(a_index_bound, (fvalid |-> (fk <= last_idx)), "byte index past frame end")
  `SRF_ASSERT(a_conv_done, ((working && step == STEP_LAST) |=> complete),
              "conversion did not finish")
  `SRF_ASSERT(a_index_step, ((out_fire && !at_last) |=> (fvalid && fk == $past(fk) + 1'b1)),
              "byte index did not advance")
endmodule
`default_nettype wire
